[src/csp_pkg.sv]
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and helpers of the CAN serial command parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int SEND_BUSES = 2;
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [7:0]  START_BYTE  = 8'hF1;
  localparam logic [7:0]  BINARY_BYTE = 8'hE7;
  localparam logic [19:0] SPEED_MAX   = 20'd1000000;

  // Command codes
  localparam logic [7:0] CMD_BUILD    = 8'd0;
  localparam logic [7:0] CMD_TSYNC    = 8'd1;
  localparam logic [7:0] CMD_DIGIN    = 8'd2;
  localparam logic [7:0] CMD_ANAIN    = 8'd3;
  localparam logic [7:0] CMD_DIGOUT   = 8'd4;
  localparam logic [7:0] CMD_SETUP    = 8'd5;
  localparam logic [7:0] CMD_PARAMS   = 8'd6;
  localparam logic [7:0] CMD_INFO     = 8'd7;
  localparam logic [7:0] CMD_SWMODE   = 8'd8;
  localparam logic [7:0] CMD_KEEPLIVE = 8'd9;
  localparam logic [7:0] CMD_SYSTYPE  = 8'd10;
  localparam logic [7:0] CMD_ECHO     = 8'd11;
  localparam logic [7:0] CMD_BUSCNT   = 8'd12;
  localparam logic [7:0] CMD_EXTBUS   = 8'd13;
  localparam logic [7:0] CMD_SETEXT   = 8'd14;

  // Configuration register indexes
  localparam logic REG_BUILD  = 1'b0;
  localparam logic REG_BUSCNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD, ST_BUILD, ST_TSYNC, ST_DIGOUT,
    ST_SETUP, ST_SWMODE, ST_SYSTYPE, ST_ECHO, ST_EXTBUS
  } parse_state_t;

  typedef enum logic [2:0] {
    KIND_REPLY, KIND_CONSOLE, KIND_SEND, KIND_ECHO, KIND_BUS
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [3:0]   code;
    logic [7:0]   data_byte;
    logic [30:0]  id;
    logic         ext;
    logic [1:0]   fbus;
    logic [3:0]   len;
    logic [63:0]  data;
    logic         bidx;
    logic         ben;
    logic         blst;
    logic [19:0]  bspd;
    logic [31:0]  now;
    logic [1:0]   snap_en;
    logic [1:0]   snap_lst;
    logic [19:0]  snap_rate0;
    logic [19:0]  snap_rate1;
  } job_t;

  // Total reply length including start byte, code and checksum
  function automatic logic [4:0] reply_total(input logic [3:0] code);
    logic [4:0] n;
    case (code)
      CMD_TSYNC[3:0]:    n = 5'd7;
      CMD_DIGIN[3:0]:    n = 5'd4;
      CMD_ANAIN[3:0]:    n = 5'd17;
      CMD_PARAMS[3:0]:   n = 5'd13;
      CMD_INFO[3:0]:     n = 5'd9;
      CMD_KEEPLIVE[3:0]: n = 5'd5;
      CMD_BUSCNT[3:0]:   n = 5'd4;
      CMD_EXTBUS[3:0]:   n = 5'd18;
      default:           n = 5'd3;
    endcase
    return n;
  endfunction

endpackage

[src/csp_if.sv]
// ----------------------------------------------------------------------------
// csp interfaces
// Input byte, result and configuration channels.
// ----------------------------------------------------------------------------
interface csp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_us;
  modport source (output valid, rx_byte, now_us, input ready);
  modport sink   (input valid, rx_byte, now_us, output ready);
endinterface

interface csp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [30:0] frame_id;
  logic        frame_ext;
  logic [1:0]  frame_bus;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;
  logic        bus_index;
  logic        bus_enable;
  logic        bus_listen;
  logic [19:0] bus_speed;
  modport source (output valid, kind, out_byte, last, frame_id, frame_ext, frame_bus,
                  frame_len, frame_data, bus_index, bus_enable, bus_listen, bus_speed,
                  input ready);
  modport sink   (input valid, kind, out_byte, last, frame_id, frame_ext, frame_bus,
                  frame_len, frame_data, bus_index, bus_enable, bus_listen, bus_speed,
                  output ready);
endinterface

interface csp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/csp_front.sv]
// ----------------------------------------------------------------------------
// csp_front
// Parses host bytes, keeps frame and bus state, and queues one job per byte
// that causes results.
// ----------------------------------------------------------------------------
module csp_front import csp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  csp_in_if.sink       rx,
  input  logic [1:0]   bus_count,
  input  logic         q_full,
  output logic         push,
  output job_t         push_job
);

  parse_state_t parse_state, parse_state_next;
  logic [3:0]   step_count, step_count_next;
  logic [31:0]  word_accum, word_accum_next;
  logic [30:0]  cur_id, cur_id_next;
  logic         cur_ext, cur_ext_next;
  logic [1:0]   cur_bus, cur_bus_next;
  logic [3:0]   cur_len, cur_len_next;
  logic [7:0]   cur_data [8];
  logic [7:0]   cur_data_next [8];
  logic [1:0]   bus_enabled, bus_enabled_next;
  logic [1:0]   bus_listen_only, bus_listen_only_next;
  logic [19:0]  bus_rate [2];
  logic [19:0]  bus_rate_next [2];
  logic [7:0]   system_type, system_type_next;
  logic         binary_mode, binary_mode_next;

  logic        take;
  logic [7:0]  b;
  logic        in_frame;
  logic        frame_done;
  logic [1:0]  bus_mask;
  logic [3:0]  len_cap;
  logic [19:0] spd;
  logic        setup_apply;
  logic        setup_idx;
  logic        setup_allowed;
  logic [63:0] frame_bits;

  assign rx.ready = !q_full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign in_frame = (parse_state == ST_BUILD) || (parse_state == ST_ECHO);
  assign bus_mask = (parse_state == ST_BUILD) ? 2'b11 : 2'b01;
  assign len_cap  = (b[3:0] > 4'd8) ? 4'd8 : b[3:0];
  assign frame_done = (step_count > 4'd5) &&
                      ({1'b0, step_count} >= ({1'b0, cur_len} + 5'd6));

  // Word assembly, little end first
  always_comb begin
    if (step_count[1:0] == 2'd0) begin
      word_accum_next = {24'd0, b};
    end else begin
      word_accum_next = word_accum | ({24'd0, b} << {step_count[1:0], 3'b000});
    end
  end

  assign spd = (word_accum_next[19:0] > SPEED_MAX) ? SPEED_MAX : word_accum_next[19:0];
  assign setup_apply   = (parse_state == ST_SETUP) &&
                         ((step_count == 4'd3) || (step_count == 4'd7));
  assign setup_idx     = (step_count == 4'd7);
  assign setup_allowed = !setup_idx || (bus_count > 2'd1);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      frame_bits[8*i +: 8] = (4'(i) < cur_len) ? cur_data[i] : 8'd0;
    end
  end

  // Next parse state
  always_comb begin
    parse_state_next = parse_state;
    case (parse_state)
      ST_IDLE: begin
        if (b == START_BYTE) parse_state_next = ST_CMD;
      end
      ST_CMD: begin
        case (b)
          CMD_BUILD:  parse_state_next = ST_BUILD;
          CMD_TSYNC:  parse_state_next = ST_TSYNC;
          CMD_DIGIN, CMD_ANAIN, CMD_PARAMS, CMD_INFO, CMD_KEEPLIVE, CMD_BUSCNT,
          CMD_EXTBUS: parse_state_next = ST_IDLE;
          CMD_DIGOUT: parse_state_next = ST_DIGOUT;
          CMD_SETUP:  parse_state_next = ST_SETUP;
          CMD_SWMODE: parse_state_next = ST_SWMODE;
          CMD_SYSTYPE: parse_state_next = ST_SYSTYPE;
          CMD_ECHO:   parse_state_next = ST_ECHO;
          CMD_SETEXT: parse_state_next = ST_EXTBUS;
          default:    parse_state_next = ST_CMD;
        endcase
      end
      ST_BUILD, ST_ECHO: begin
        if (frame_done) parse_state_next = ST_IDLE;
      end
      ST_SETUP: begin
        if (step_count == 4'd7) parse_state_next = ST_IDLE;
      end
      ST_EXTBUS: begin
        if (step_count >= 4'd11) parse_state_next = ST_IDLE;
      end
      default: parse_state_next = ST_IDLE;
    endcase
  end

  // Data path and job output
  always_comb begin
    step_count_next      = step_count;
    cur_id_next          = cur_id;
    cur_ext_next         = cur_ext;
    cur_bus_next         = cur_bus;
    cur_len_next         = cur_len;
    cur_data_next        = cur_data;
    bus_enabled_next     = bus_enabled;
    bus_listen_only_next = bus_listen_only;
    bus_rate_next        = bus_rate;
    system_type_next     = system_type;
    binary_mode_next     = binary_mode;
    push                 = 1'b0;
    push_job             = '0;

    case (parse_state)
      ST_IDLE: begin
        if (b == BINARY_BYTE) begin
          binary_mode_next = 1'b1;
        end else if (b != START_BYTE) begin
          push               = 1'b1;
          push_job.kind      = KIND_CONSOLE;
          push_job.data_byte = b;
        end
      end
      ST_CMD: begin
        if (b <= CMD_SETEXT) step_count_next = 4'd0;
        case (b)
          CMD_TSYNC, CMD_DIGIN, CMD_ANAIN, CMD_PARAMS, CMD_INFO, CMD_KEEPLIVE,
          CMD_BUSCNT, CMD_EXTBUS: begin
            push                = 1'b1;
            push_job.kind       = KIND_REPLY;
            push_job.code       = b[3:0];
            push_job.now        = rx.now_us;
            push_job.snap_en    = bus_enabled;
            push_job.snap_lst   = bus_listen_only;
            push_job.snap_rate0 = bus_rate[0];
            push_job.snap_rate1 = bus_rate[1];
          end
          default: ;
        endcase
      end
      ST_BUILD, ST_ECHO: begin
        step_count_next = step_count + 4'd1;
        case (step_count)
          4'd0: cur_id_next = {23'd0, b};
          4'd1: cur_id_next[15:8]  = b;
          4'd2: cur_id_next[23:16] = b;
          4'd3: begin
            cur_id_next[30:24] = b[6:0];
            cur_ext_next       = b[7];
          end
          4'd4: cur_bus_next = b[1:0] & bus_mask;
          4'd5: cur_len_next = len_cap;
          default: begin
            if (!frame_done) cur_data_next[step_count[2:0] - 3'd6] = b;
          end
        endcase
        if (frame_done && ((parse_state == ST_ECHO) || (32'(cur_bus) < SEND_BUSES))) begin
          push          = 1'b1;
          push_job.kind = (parse_state == ST_ECHO) ? KIND_ECHO : KIND_SEND;
          push_job.id   = cur_id;
          push_job.ext  = cur_ext;
          push_job.fbus = cur_bus;
          push_job.len  = cur_len;
          push_job.data = frame_bits;
        end
      end
      ST_SETUP: begin
        step_count_next = step_count + 4'd1;
        if (setup_apply) begin
          if ((word_accum_next != 32'd0) && setup_allowed) begin
            if (word_accum_next[31]) begin
              bus_enabled_next[setup_idx]     = word_accum_next[30];
              bus_listen_only_next[setup_idx] = word_accum_next[29];
            end else begin
              bus_enabled_next[setup_idx] = 1'b1;
            end
            bus_rate_next[setup_idx] = spd;
          end else begin
            bus_enabled_next[setup_idx] = 1'b0;
          end
          push          = 1'b1;
          push_job.kind = KIND_BUS;
          push_job.bidx = setup_idx;
          push_job.ben  = bus_enabled_next[setup_idx];
          push_job.blst = bus_listen_only_next[setup_idx];
          push_job.bspd = bus_rate_next[setup_idx];
        end
      end
      ST_EXTBUS: step_count_next = step_count + 4'd1;
      ST_SYSTYPE: system_type_next = b;
      default: ;
    endcase
    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_IDLE;
      step_count      <= '0;
      word_accum      <= '0;
      cur_id          <= '0;
      cur_ext         <= 1'b0;
      cur_bus         <= '0;
      cur_len         <= '0;
      cur_data        <= '{default: 8'd0};
      bus_enabled     <= '0;
      bus_listen_only <= '0;
      bus_rate        <= '{default: 20'd0};
      system_type     <= '0;
      binary_mode     <= 1'b0;
    end else if (take) begin
      parse_state     <= parse_state_next;
      step_count      <= step_count_next;
      if ((parse_state == ST_SETUP) || (parse_state == ST_EXTBUS)) begin
        word_accum <= word_accum_next;
      end
      cur_id          <= cur_id_next;
      cur_ext         <= cur_ext_next;
      cur_bus         <= cur_bus_next;
      cur_len         <= cur_len_next;
      cur_data        <= cur_data_next;
      bus_enabled     <= bus_enabled_next;
      bus_listen_only <= bus_listen_only_next;
      bus_rate        <= bus_rate_next;
      system_type     <= system_type_next;
      binary_mode     <= binary_mode_next;
    end
  end

  // in_frame only used for the cross-check below
  frame_state_a: assert property (@(posedge clk) disable iff (rst)
    (take && in_frame && frame_done) |=> (parse_state == ST_IDLE))
    else $error("frame end did not return to idle");

  setup_end_a: assert property (@(posedge clk) disable iff (rst)
    (take && (parse_state == ST_SETUP) && (step_count == 4'd7)) |=>
      (parse_state == ST_IDLE))
    else $error("bus setup did not end after second word");

  len_cap_a: assert property (@(posedge clk) disable iff (rst) cur_len <= 4'd8)
    else $error("frame length above cap");

endmodule

[src/csp_queue.sv]
// ----------------------------------------------------------------------------
// csp_queue
// Short job queue between the parser and the result generator.
// ----------------------------------------------------------------------------
module csp_queue import csp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  localparam int CW = $clog2(QDEPTH + 1);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  no_overflow_a: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  no_underflow_a: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

  count_track_a: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count out of step");

endmodule

[src/csp_back.sv]
// ----------------------------------------------------------------------------
// csp_back
// Expands queued jobs into result items; replies go out byte by byte with
// a running XOR checksum.
// ----------------------------------------------------------------------------
module csp_back import csp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  job_t         head,
  input  logic [15:0]  build_number,
  input  logic [1:0]   bus_count,
  output logic         pop,
  csp_out_if.source    tx
);

  logic [4:0]  idx;
  logic [7:0]  chk;
  logic [4:0]  total;
  logic        final_item;
  logic        advance;
  logic        fire;
  logic [4:0]  k;
  logic [7:0]  body;
  logic [7:0]  rbyte;

  logic        valid;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [30:0] frame_id;
  logic        frame_ext;
  logic [1:0]  frame_bus;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;
  logic        bus_index;
  logic        bus_enable;
  logic        bus_listen;
  logic [19:0] bus_speed;

  assign total      = (head.kind == KIND_REPLY) ? reply_total(head.code) : 5'd1;
  assign final_item = (idx == total - 5'd1);
  assign advance    = !valid || tx.ready;
  assign fire       = head_valid && advance;
  assign pop        = fire && final_item;
  assign k          = idx - 5'd2;

  always_comb begin
    body = 8'd0;
    case ({4'd0, head.code})
      CMD_TSYNC: begin
        case (k)
          5'd0: body = head.now[7:0];
          5'd1: body = head.now[15:8];
          5'd2: body = head.now[23:16];
          5'd3: body = head.now[31:24];
          default: body = 8'd0;
        endcase
      end
      CMD_PARAMS: begin
        case (k)
          5'd0: body = {3'd0, head.snap_lst[0], 3'd0, head.snap_en[0]};
          5'd1: body = head.snap_rate0[7:0];
          5'd2: body = head.snap_rate0[15:8];
          5'd3: body = {4'd0, head.snap_rate0[19:16]};
          5'd5: body = {3'd0, head.snap_lst[1], 3'd0, head.snap_en[1]};
          5'd6: body = head.snap_rate1[7:0];
          5'd7: body = head.snap_rate1[15:8];
          5'd8: body = {4'd0, head.snap_rate1[19:16]};
          default: body = 8'd0;
        endcase
      end
      CMD_INFO: begin
        case (k)
          5'd0: body = build_number[7:0];
          5'd1: body = build_number[15:8];
          5'd2: body = 8'h20;
          default: body = 8'd0;
        endcase
      end
      CMD_KEEPLIVE: begin
        case (k)
          5'd0: body = 8'hDE;
          5'd1: body = 8'hAD;
          default: body = 8'd0;
        endcase
      end
      CMD_BUSCNT: body = {6'd0, bus_count};
      default: body = 8'd0;
    endcase
  end

  always_comb begin
    if (idx == 5'd0)      rbyte = START_BYTE;
    else if (idx == 5'd1) rbyte = {4'd0, head.code};
    else if (final_item)  rbyte = chk;
    else                  rbyte = body;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      chk   <= '0;
      valid <= 1'b0;
    end else begin
      if (fire) begin
        valid <= 1'b1;
        idx   <= final_item ? 5'd0 : idx + 5'd1;
        chk   <= final_item ? 8'd0 : chk ^ rbyte;
      end else if (tx.ready) begin
        valid <= 1'b0;
      end
    end
  end

  // Payload register: load on each produced item
  always_ff @(posedge clk) begin
    if (fire) begin
      kind       <= head.kind;
      last       <= final_item;
      out_byte   <= (head.kind == KIND_REPLY)   ? rbyte :
                    (head.kind == KIND_CONSOLE) ? head.data_byte : 8'd0;
      frame_id   <= head.id;
      frame_ext  <= head.ext;
      frame_bus  <= head.fbus;
      frame_len  <= head.len;
      frame_data <= head.data;
      bus_index  <= head.bidx;
      bus_enable <= head.ben;
      bus_listen <= head.blst;
      bus_speed  <= head.bspd;
    end
  end

  assign tx.valid      = valid;
  assign tx.kind       = kind;
  assign tx.out_byte   = out_byte;
  assign tx.last       = last;
  assign tx.frame_id   = frame_id;
  assign tx.frame_ext  = frame_ext;
  assign tx.frame_bus  = frame_bus;
  assign tx.frame_len  = frame_len;
  assign tx.frame_data = frame_data;
  assign tx.bus_index  = bus_index;
  assign tx.bus_enable = bus_enable;
  assign tx.bus_listen = bus_listen;
  assign tx.bus_speed  = bus_speed;

  idx_range_a: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < total))
    else $error("reply index beyond reply length");

  idx_reset_a: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 5'd0))
    else $error("reply index not cleared after job");

  start_byte_a: assert property (@(posedge clk) disable iff (rst)
    (fire && (head.kind == KIND_REPLY) && (idx == 5'd0)) |=> (out_byte == START_BYTE))
    else $error("reply did not open with start byte");

endmodule

[src/can_serial_command_parser.sv]
// ----------------------------------------------------------------------------
// can_serial_command_parser
// Host byte parser for a CAN adapter: console pass-through, frame assembly,
// bus setup and checksummed query replies.
//
//   channel  dir  handshake     payload
//   rx       in   valid/ready   rx_byte, now_us
//   tx       out  valid/ready   kind, out_byte, last, frame_*, bus_*
//   cfg      in   valid/ready   index, data
//
// The parser takes one byte a cycle while the two-entry job queue has room.
// Each job leaves as one or more results, one a cycle while tx accepts them; a reply
// is 4 to 18 bytes long, set by the byte sequencer in the back end.
// rst is synchronous and clears parser, queue and result register.
// A stalled tx holds the result register; the queue then fills and rx.ready drops.
// ----------------------------------------------------------------------------
module can_serial_command_parser import csp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  csp_in_if.sink    rx,
  csp_out_if.source tx,
  csp_cfg_if.sink   cfg
);

  logic [15:0] build_number;
  logic [1:0]  bus_count;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        head_valid;
  job_t        push_job;
  job_t        head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      build_number <= '0;
      bus_count    <= 2'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BUILD:  build_number <= cfg.data;
        REG_BUSCNT: bus_count    <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  csp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .bus_count (bus_count),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  csp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  csp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .build_number (build_number),
    .bus_count    (bus_count),
    .pop          (pop),
    .tx           (tx)
  );

endmodule

[tb/csp_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csp_tb_if
// Testbench-side view of the parser channels.
//
// The block's own interface file declares the rx, tx and cfg channels; this
// file holds the shared result record that the byte sender and the result
// checker exchange.
// ----------------------------------------------------------------------------
package csp_tb_pkg;
  import csp_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [30:0] frame_id;
    logic        frame_ext;
    logic [1:0]  frame_bus;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        bus_index;
    logic        bus_enable;
    logic        bus_listen;
    logic [19:0] bus_speed;
  } result_t;
endpackage

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CAN serial command parser.
//
// Streams host bytes into the parser, predicts every reply, console byte,
// frame and bus setting, and checks each transfer on the result channel in
// order. Both sides idle in random bursts; one long receiver hold-off fills
// the job queue and stalls the input.
// ----------------------------------------------------------------------------
module testbench;
  import csp_pkg::*;
  import csp_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csp_in_if  rx ();
  csp_out_if tx ();
  csp_cfg_if cfg ();

  can_serial_command_parser uut (.clk(clk), .rst(rst), .rx(rx), .tx(tx), .cfg(cfg));

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state
  logic [15:0]  p_build;
  logic [1:0]   p_buscnt;
  parse_state_t p_state;
  logic [3:0]   p_step;
  logic [31:0]  p_word;
  logic [31:0]  p_id;
  logic         p_ext;
  logic [1:0]   p_bus;
  logic [3:0]   p_len;
  logic [7:0]   p_data [8];
  logic         p_en [2];
  logic         p_lst [2];
  logic [19:0]  p_rate [2];

  result_t expected_results[$];
  result_t new_res[$];
  logic [7:0] reply_buf[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  drain_quiet = 1'b0;   // no idling in the last part
  bit  hold_off = 1'b0;
  int  hold_len = 0;

  function automatic result_t blank(input logic [2:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic void put_reply(input logic [7:0] b);
    if (reply_buf.size() < 18) reply_buf.push_back(b);
  endfunction

  function automatic void flush_reply();
    logic [7:0] x;
    result_t r;
    x = 8'h00;
    foreach (reply_buf[i]) x ^= reply_buf[i];
    put_reply(x);
    foreach (reply_buf[i]) begin
      r = blank(KIND_REPLY);
      r.out_byte = reply_buf[i];
      new_res.push_back(r);
    end
    reply_buf.delete();
  endfunction

  function automatic void start_reply(input logic [7:0] code);
    reply_buf.delete();
    put_reply(START_BYTE);
    put_reply(code);
  endfunction

  function automatic void push_frame(input logic [2:0] k);
    result_t r;
    r = blank(k);
    for (int i = 0; i < 8; i++)
      if (i < p_len) r.frame_data[8*i +: 8] = p_data[i];
    r.frame_id  = p_id[30:0];
    r.frame_ext = p_ext;
    r.frame_bus = p_bus;
    r.frame_len = p_len;
    new_res.push_back(r);
  endfunction

  function automatic bit frame_collect(input logic [7:0] b, input logic [1:0] mask);
    bit done;
    done = 1'b0;
    case (p_step)
      4'd0: p_id = {24'd0, b};
      4'd1: p_id[15:8] = b;
      4'd2: p_id[23:16] = b;
      4'd3: begin
        p_id[31:24] = b;
        p_ext = p_id[31];
        p_id[31] = 1'b0;
      end
      4'd4: p_bus = b[1:0] & mask;
      4'd5: p_len = (b[3:0] > 4'd8) ? 4'd8 : b[3:0];
      default: begin
        if (p_step < p_len + 6) p_data[3'(p_step - 4'd6)] = b;
        else begin
          p_state = ST_IDLE;
          done = 1'b1;
        end
      end
    endcase
    p_step = p_step + 4'd1;
    return done;
  endfunction

  function automatic void bus_update(input logic idx, input bit allowed);
    logic [19:0] spd;
    result_t r;
    spd = (p_word[19:0] > SPEED_MAX) ? SPEED_MAX : p_word[19:0];
    if (p_word != 0 && allowed) begin
      if (p_word[31]) begin
        p_en[idx]  = p_word[30];
        p_lst[idx] = p_word[29];
      end else p_en[idx] = 1'b1;
      p_rate[idx] = spd;
    end else p_en[idx] = 1'b0;
    r = blank(KIND_BUS);
    r.bus_index  = idx;
    r.bus_enable = p_en[idx];
    r.bus_listen = p_lst[idx];
    r.bus_speed  = p_rate[idx];
    new_res.push_back(r);
  endfunction

  function automatic void word_collect(input logic [7:0] b);
    if (p_step[1:0] == 2'd0) p_word = {24'd0, b};
    else p_word[8*p_step[1:0] +: 8] = b;
  endfunction

  function automatic void run_command(input logic [7:0] b, input logic [31:0] now);
    case (b)
      CMD_BUILD:  begin p_state = ST_BUILD; p_step = 4'd0; end
      CMD_TSYNC: begin
        p_state = ST_TSYNC; p_step = 4'd0;
        start_reply(CMD_TSYNC);
        for (int i = 0; i < 4; i++) put_reply(now[8*i +: 8]);
        flush_reply();
      end
      CMD_DIGIN: begin
        start_reply(CMD_DIGIN); put_reply(8'h00); flush_reply(); p_state = ST_IDLE;
      end
      CMD_ANAIN: begin
        start_reply(CMD_ANAIN);
        for (int i = 0; i < 14; i++) put_reply(8'h00);
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_DIGOUT: p_state = ST_DIGOUT;
      CMD_SETUP:  begin p_state = ST_SETUP; p_step = 4'd0; end
      CMD_PARAMS: begin
        start_reply(CMD_PARAMS);
        for (int i = 0; i < 2; i++) begin
          put_reply({3'b000, p_lst[i], 3'b000, p_en[i]});
          put_reply(p_rate[i][7:0]);
          put_reply(p_rate[i][15:8]);
          put_reply({4'h0, p_rate[i][19:16]});
          put_reply(8'h00);
        end
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_INFO: begin
        start_reply(CMD_INFO);
        put_reply(p_build[7:0]); put_reply(p_build[15:8]);
        put_reply(8'h20); put_reply(8'h00); put_reply(8'h00); put_reply(8'h00);
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_SWMODE: begin p_state = ST_SWMODE; p_step = 4'd0; end
      CMD_KEEPLIVE: begin
        start_reply(CMD_KEEPLIVE); put_reply(8'hDE); put_reply(8'hAD);
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_SYSTYPE: begin p_state = ST_SYSTYPE; p_step = 4'd0; end
      CMD_ECHO:    begin p_state = ST_ECHO; p_step = 4'd0; end
      CMD_BUSCNT: begin
        start_reply(CMD_BUSCNT); put_reply({6'd0, p_buscnt});
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_EXTBUS: begin
        start_reply(CMD_EXTBUS);
        for (int i = 0; i < 15; i++) put_reply(8'h00);
        flush_reply(); p_state = ST_IDLE;
      end
      CMD_SETEXT: begin p_state = ST_EXTBUS; p_step = 4'd0; end
      default: ;
    endcase
  endfunction

  // Predict the results of one host byte and queue them
  function automatic void predict_byte(input logic [7:0] b, input logic [31:0] now);
    result_t r;
    new_res.delete();
    case (p_state)
      ST_IDLE: begin
        if (b == START_BYTE) p_state = ST_CMD;
        else if (b != BINARY_BYTE) begin
          r = blank(KIND_CONSOLE);
          r.out_byte = b;
          new_res.push_back(r);
        end
      end
      ST_CMD:   run_command(b, now);
      ST_BUILD: if (frame_collect(b, 2'd3) && p_bus < SEND_BUSES) push_frame(KIND_SEND);
      ST_ECHO:  if (frame_collect(b, 2'd1)) push_frame(KIND_ECHO);
      ST_SETUP: begin
        word_collect(b);
        if (p_step == 4'd3) bus_update(1'b0, 1'b1);
        else if (p_step == 4'd7) begin
          bus_update(1'b1, p_buscnt > 2'd1);
          p_state = ST_IDLE;
        end
        p_step = p_step + 4'd1;
      end
      ST_EXTBUS: begin
        word_collect(b);
        if (p_step >= 4'd11) p_state = ST_IDLE;
        p_step = p_step + 4'd1;
      end
      default: p_state = ST_IDLE;
    endcase
    if (new_res.size() > 0) new_res[new_res.size()-1].last = 1'b1;
    foreach (new_res[i]) expected_results.push_back(new_res[i]);
  endfunction

  // Sender; valid stays up between back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic [31:0] now);
    if (!drain_quiet && $urandom_range(0, 5) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    rx.now_us  <= now;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    predict_byte(b, now);
  endtask

  task automatic send_rand_byte(input logic [7:0] b);
    send_byte(b, $urandom());
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_BUILD) p_build = val;
    else p_buscnt = val[1:0];
    @(posedge clk);
  endtask

  task automatic wait_idle();
    rx.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [31:0] id,
                            input logic [7:0] bus, input logic [7:0] len);
    send_byte(START_BYTE, $urandom());
    send_byte(cmd, $urandom());
    for (int i = 0; i < 4; i++) send_rand_byte(id[8*i +: 8]);
    send_rand_byte(bus);
    send_rand_byte(len);
    for (int i = 0; i < ((len[3:0] > 8) ? 8 : len[3:0]); i++)
      send_rand_byte(8'($urandom()));
    send_rand_byte(8'($urandom()));
  endtask

  task automatic send_setup(input logic [31:0] w0, input logic [31:0] w1);
    send_rand_byte(START_BYTE);
    send_rand_byte(CMD_SETUP);
    for (int i = 0; i < 4; i++) send_rand_byte(w0[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_rand_byte(w1[8*i +: 8]);
  endtask

  task automatic send_cmd(input logic [7:0] c);
    send_rand_byte(START_BYTE);
    send_rand_byte(c);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 32'h0);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(BINARY_BYTE, 32'h0);
    send_byte(START_BYTE, 32'h0);
    send_byte(CMD_TSYNC, 32'hFFFF_FFFF);
    send_byte(8'hAA, 32'h0);            // swallowed after time sync
    send_frame(CMD_BUILD, 32'hFFFF_FFFF, 8'h01, 8'hFF);
    send_frame(CMD_BUILD, 32'h0000_0000, 8'h02, 8'h00);  // bus out of range
    send_frame(CMD_ECHO, 32'h8000_0123, 8'hFF, 8'h03);
    send_setup(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_all_commands();
    for (int c = 0; c < 16; c++) begin
      if (c == CMD_BUILD || c == CMD_ECHO)
        send_frame(c[7:0], $urandom(), 8'($urandom()), 8'($urandom()));
      else begin
        send_cmd(c[7:0]);
        if (c == CMD_SETEXT) for (int i = 0; i < 12; i++) send_rand_byte(8'($urandom()));
        else if (c == CMD_SETUP) for (int i = 0; i < 8; i++) send_rand_byte(8'($urandom()));
        else if (c == CMD_DIGOUT || c == CMD_SWMODE || c == CMD_SYSTYPE || c == CMD_TSYNC)
          send_rand_byte(8'($urandom()));
      end
    end
  endtask

  task automatic test_random(input int n);
    int sent;
    logic [31:0] w;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0: begin send_rand_byte(8'($urandom())); sent++; end
        1, 2: begin
          send_frame($urandom_range(0, 1) ? CMD_BUILD : CMD_ECHO, $urandom(),
                     8'($urandom()), 8'($urandom()));
          sent += 12;
        end
        3: begin
          w = $urandom();
          send_setup($urandom_range(0, 3) == 0 ? 32'h0 : w, $urandom());
          sent += 10;
        end
        4: begin
          // broken sequence: start then random byte
          send_cmd(8'($urandom()));
          sent += 2;
        end
        default: begin
          send_cmd(8'($urandom_range(1, 13)));
          sent += 2;
        end
      endcase
    end
  endtask

  task automatic test_pressure();
    hold_len = 300;
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_cmd(CMD_ANAIN);
    if (hold_off) begin
      rx.valid <= 1'b0;
      while (hold_off) @(posedge clk);
    end
  endtask

  // Receiver ready, random bursts and one long hold-off
  initial begin
    tx.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        tx.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_off = 1'b0;
      end else if (!drain_quiet && $urandom_range(0, 7) == 0) begin
        tx.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
      end else tx.ready <= 1'b1;
    end
  end

  // Result checker
  initial begin
    result_t got, exp_r;
    forever begin
      @(posedge clk);
      if (!rst && tx.valid && tx.ready) begin
        got = '{tx.kind, tx.out_byte, tx.last, tx.frame_id, tx.frame_ext, tx.frame_bus,
                tx.frame_len, tx.frame_data, tx.bus_index, tx.bus_enable,
                tx.bus_listen, tx.bus_speed};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %h actual %h", exp_r, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if ((rx.valid && rx.ready) || (tx.valid && tx.ready) || (cfg.valid && cfg.ready)
          || hold_off)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic reset_model();
    p_build = 16'd0; p_buscnt = 2'd2; p_state = ST_IDLE; p_step = 4'd0; p_word = 32'd0;
    p_id = 32'd0; p_ext = 1'b0; p_bus = 2'd0; p_len = 4'd0;
    for (int i = 0; i < 8; i++) p_data[i] = 8'h00;
    for (int i = 0; i < 2; i++) begin
      p_en[i] = 1'b0; p_lst[i] = 1'b0; p_rate[i] = 20'd0;
    end
  endtask

  initial begin
    rx.valid = 1'b0; rx.rx_byte = 8'h00; rx.now_us = 32'h0;
    cfg.valid = 1'b0; cfg.index = REG_BUILD; cfg.data = 16'h0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_all_commands();
    wait_idle();
    write_reg(REG_BUILD, 16'hFFFF);
    write_reg(REG_BUSCNT, 16'd1);
    send_cmd(CMD_INFO); send_cmd(CMD_BUSCNT);
    send_setup(32'hE00F_FFFF, 32'h0001_0000);
    test_random(5);
    test_pressure();
    wait_idle();
    write_reg(REG_BUILD, 16'h0000);
    write_reg(REG_BUSCNT, 16'd2);
    send_cmd(CMD_INFO); send_cmd(CMD_BUSCNT);
    test_random(5);
    wait_idle();
    write_reg(REG_BUILD, 16'($urandom()));
    drain_quiet = 1'b1;
    test_random(5);
    send_cmd(CMD_PARAMS);
    wait_idle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[can_serial_command_parser.f]
src/csp_pkg.sv
src/csp_if.sv
src/csp_front.sv
src/csp_queue.sv
src/csp_back.sv
src/can_serial_command_parser.sv
tb/csp_tb_if.sv
tb/testbench.sv
